### sv/clnw_pkg.sv
// clnw_pkg: shared types and constants of the character lcd nibble writer
// request and result structs, opcodes, register indexes, lcd command bytes, step codes
// no dependencies
package clnw_pkg;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] byte_value;
    logic [3:0] column;
    logic       row;
  } in_item_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_before_us;
    logic [15:0] wait_after_us;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        init_seq;
    logic        clear_seq;
    logic        line_cmd;
    logic [7:0]  line_byte;
    logic        final_en;
    logic        final_rs;
    logic [7:0]  final_byte;
  } job_t;

  typedef struct packed {
    logic [14:0] settle_wait_us;
    logic [14:0] home_wait_us;
    logic [15:0] power_up_wait_us;
  } cfg_t;

  localparam logic [2:0] OP_COMMAND  = 3'd0;
  localparam logic [2:0] OP_CHAR     = 3'd1;
  localparam logic [2:0] OP_LOCATION = 3'd2;
  localparam logic [2:0] OP_RAW      = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_PULSE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_WAIT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOME_WAIT    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_UP     = 2'd3;

  localparam logic [14:0] SETTLE_WAIT_RESET = 15'd100;
  localparam logic [14:0] HOME_WAIT_RESET   = 15'd1900;
  localparam logic [15:0] POWER_UP_RESET    = 16'd15000;

  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_HOME    = 8'h02;
  localparam logic [7:0] CMD_LINE1   = 8'h80;
  localparam logic [7:0] CMD_LINE2   = 8'hC0;
  localparam logic [7:0] CMD_INIT8   = 8'h33;
  localparam logic [7:0] CMD_INIT4   = 8'h32;
  localparam logic [7:0] CMD_FUNC    = 8'h28;
  localparam logic [7:0] CMD_DISP_ON = 8'h0E;
  localparam logic [7:0] CMD_INC     = 8'h06;
  localparam logic [7:0] CMD_DEC     = 8'h04;
  localparam logic [7:0] CMD_SHIFT_L = 8'h07;
  localparam logic [7:0] CMD_SHIFT_R = 8'h05;

  localparam int STEP_COUNT = 11;
  localparam int STEP_W     = 4;
  localparam logic [STEP_W-1:0] STEP_INIT8      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_INIT4      = 4'd1;
  localparam logic [STEP_W-1:0] STEP_FUNC       = 4'd2;
  localparam logic [STEP_W-1:0] STEP_DISP_ON    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ENTRY      = 4'd4;
  localparam logic [STEP_W-1:0] STEP_INIT_CLEAR = 4'd5;
  localparam logic [STEP_W-1:0] STEP_INIT_HOME  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_CLEAR      = 4'd7;
  localparam logic [STEP_W-1:0] STEP_HOME       = 4'd8;
  localparam logic [STEP_W-1:0] STEP_LINE       = 4'd9;
  localparam logic [STEP_W-1:0] STEP_FINAL      = 4'd10;

endpackage

### sv/clnw_fifo.sv
// clnw_fifo: small register queue with full and empty flags
// generic width and depth, used between the front, the back and the result port
// no dependencies
module clnw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

### sv/clnw_front.sv
// clnw_front: accepts requests, tracks init, cursor and direction state
// turns each request of opcode 0-4 into a job descriptor of byte steps for the back
// depends on clnw_pkg
module clnw_front
  import clnw_pkg::*;
#(
  parameter int LINE_LENGTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t in_item,
  output logic     full,
  input  logic     job_full,
  output logic     job_push,
  output job_t     job
);

  function automatic logic [255:0] stride_mask(input int stride);
    logic [255:0] m;
    m = '0;
    for (int k = 0; k < 256; k += stride) begin
      m[k] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [255:0] SpanMask = stride_mask(2 * LINE_LENGTH);
  localparam logic [255:0] LineMask = stride_mask(LINE_LENGTH);

  logic       initialized;
  logic       initialized_next;
  logic [7:0] cursor_count;
  logic [7:0] cursor_count_next;
  logic       cursor_decrement;
  logic       cursor_decrement_next;
  logic       accept;
  logic       need_init;
  logic [7:0] count_eff;
  logic       dec_eff;

  assign full   = job_full;
  assign accept = push && !full;

  always_comb begin
    need_init = !initialized && ((in_item.opcode == OP_CHAR) ||
                (in_item.opcode == OP_LOCATION) || (in_item.opcode == OP_RAW));
    count_eff = need_init ? 8'd0 : cursor_count;
    dec_eff   = need_init ? 1'b0 : cursor_decrement;

    initialized_next      = initialized;
    cursor_count_next     = cursor_count;
    cursor_decrement_next = cursor_decrement;
    job                   = '0;
    job_push              = 1'b0;
    job.init_seq          = need_init;

    if (accept) begin
      case (in_item.opcode)
        OP_COMMAND: begin
          job_push       = 1'b1;
          job.final_en   = 1'b1;
          job.final_byte = in_item.byte_value;
          if ((in_item.byte_value == CMD_INC) || (in_item.byte_value == CMD_SHIFT_L)) begin
            cursor_decrement_next = 1'b0;
          end
          if ((in_item.byte_value == CMD_DEC) || (in_item.byte_value == CMD_SHIFT_R)) begin
            cursor_decrement_next = 1'b1;
          end
        end
        OP_CHAR: begin
          job_push       = 1'b1;
          job.final_en   = 1'b1;
          job.final_rs   = 1'b1;
          job.final_byte = in_item.byte_value;
          if (SpanMask[count_eff]) begin
            job.clear_seq = 1'b1;
            job.line_cmd  = 1'b1;
            job.line_byte = CMD_LINE1;
          end else if (LineMask[count_eff]) begin
            job.line_cmd  = 1'b1;
            job.line_byte = CMD_LINE2;
          end
          initialized_next      = 1'b1;
          cursor_decrement_next = dec_eff;
          cursor_count_next     = dec_eff ? count_eff - 8'd1 : count_eff + 8'd1;
        end
        OP_LOCATION: begin
          job_push       = 1'b1;
          job.final_en   = 1'b1;
          job.final_byte = CMD_LINE1 | {1'b0, in_item.row, 2'b00, in_item.column};
          initialized_next      = 1'b1;
          cursor_decrement_next = dec_eff;
          cursor_count_next     = in_item.row ? 8'(LINE_LENGTH) + {4'd0, in_item.column}
                                              : {4'd0, in_item.column};
        end
        OP_RAW: begin
          job_push       = 1'b1;
          job.final_en   = 1'b1;
          job.final_rs   = 1'b1;
          job.final_byte = in_item.byte_value;
          initialized_next      = 1'b1;
          cursor_decrement_next = dec_eff;
          cursor_count_next     = count_eff;
        end
        OP_CLEAR: begin
          job_push          = 1'b1;
          job.clear_seq     = 1'b1;
          cursor_count_next = 8'd0;
        end
        default: begin
          job_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initialized      <= 1'b0;
      cursor_count     <= 8'd0;
      cursor_decrement <= 1'b0;
    end else begin
      initialized      <= initialized_next;
      cursor_count     <= cursor_count_next;
      cursor_decrement <= cursor_decrement_next;
    end
  end

endmodule

### sv/clnw_back.sv
// clnw_back: walks the byte steps of one job, one nibble strobe per cycle while out_full is low
// fills in register select, nibble and wait times from the timing registers
// depends on clnw_pkg
module clnw_back
  import clnw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      job_empty,
  input  job_t      job,
  output logic      job_pop,
  input  logic      out_full,
  output logic      out_push,
  output out_item_t out_item
);

  logic                  busy;
  logic                  busy_next;
  logic                  half;
  logic                  half_next;
  logic [STEP_COUNT-1:0] mask;
  logic [STEP_COUNT-1:0] mask_next;
  logic [STEP_COUNT-1:0] mask_rest;
  logic [7:0]            line_byte;
  logic                  final_rs;
  logic [7:0]            final_byte;
  logic [STEP_W-1:0]     step;
  logic [7:0]            cur_byte;
  logic                  home_step;
  logic [16:0]           after_sum;
  logic                  finishing;

  always_comb begin
    step = '0;
    for (int i = STEP_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        step = STEP_W'(i);
      end
    end
  end

  always_comb begin
    case (step)
      STEP_INIT8:      cur_byte = CMD_INIT8;
      STEP_INIT4:      cur_byte = CMD_INIT4;
      STEP_FUNC:       cur_byte = CMD_FUNC;
      STEP_DISP_ON:    cur_byte = CMD_DISP_ON;
      STEP_ENTRY:      cur_byte = CMD_INC;
      STEP_INIT_CLEAR: cur_byte = CMD_CLEAR;
      STEP_INIT_HOME:  cur_byte = CMD_HOME;
      STEP_CLEAR:      cur_byte = CMD_CLEAR;
      STEP_HOME:       cur_byte = CMD_HOME;
      STEP_LINE:       cur_byte = line_byte;
      STEP_FINAL:      cur_byte = final_byte;
      default:         cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    home_step = (step == STEP_INIT_HOME) || (step == STEP_HOME);
    mask_rest = mask & ~(STEP_COUNT'(1) << step);
    after_sum = {2'b00, cfg.settle_wait_us} +
                (home_step ? {1'b0, cfg.home_wait_us, 1'b0} : 17'd0);

    out_push = busy && !out_full;
    out_item.reg_select = (step == STEP_FINAL) ? final_rs : 1'b0;
    if (!half) begin
      out_item.nibble         = cur_byte[7:4];
      out_item.wait_before_us = (step == STEP_INIT8) ? cfg.power_up_wait_us : 16'd0;
      out_item.wait_after_us  = 16'd0;
      out_item.last           = 1'b0;
    end else begin
      out_item.nibble         = cur_byte[3:0];
      out_item.wait_before_us = 16'd0;
      out_item.wait_after_us  = after_sum[16] ? 16'hFFFF : after_sum[15:0];
      out_item.last           = (mask_rest == '0);
    end

    finishing = out_push && half && (mask_rest == '0);
    job_pop   = !job_empty && (!busy || finishing);

    busy_next = busy;
    half_next = half;
    mask_next = mask;
    if (out_push) begin
      half_next = !half;
      if (half) begin
        mask_next = mask_rest;
      end
    end
    if (finishing) begin
      busy_next = 1'b0;
    end
    if (job_pop) begin
      busy_next = 1'b1;
      half_next = 1'b0;
      mask_next = {job.final_en, job.line_cmd, job.clear_seq, job.clear_seq,
                   {7{job.init_seq}}};
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      line_byte  <= job.line_byte;
      final_rs   <= job.final_rs;
      final_byte <= job.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      half <= 1'b0;
      mask <= '0;
    end else begin
      busy <= busy_next;
      half <= half_next;
      mask <= mask_next;
    end
  end

endmodule

### sv/char_lcd_nibble_writer_top.sv
// char_lcd_nibble_writer_top: 4-bit character lcd writer, request queue in, strobe queue out
// usage: push a request when full is low; each request of opcode 0-4 yields 2 to 22 strobes,
//   taken with pop while empty is low; the final strobe of a request has last set
// a front stage classifies requests and keeps init, cursor and direction state;
//   a job queue decouples it from the back stage, which emits one strobe per cycle while
//   the result queue has room, so requests are taken while earlier results wait
// throughput: one strobe per cycle from the back stage's step sequencer while the result
//   queue has room; two strobes per byte, so 2 strobes for a command and up to 22
//   for a first character with init
// when pop stalls, the result queue fills, the back stage holds, the job queue fills
//   and then full rises; nothing is lost
// reset clears all queues, the init and cursor state, and loads the default timing
// configuration: cfg_write with cfg_index and cfg_data, only while idle
// depends on clnw_pkg, clnw_fifo, clnw_front, clnw_back
module char_lcd_nibble_writer_top
  import clnw_pkg::*;
#(
  parameter int LINE_LENGTH = 16,
  parameter int JOB_DEPTH   = 2,
  parameter int OUT_DEPTH   = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  in_item_t               in_item,
  output logic                   empty,
  input  logic                   pop,
  output out_item_t              out_item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  logic      job_push;
  job_t      job_in;
  logic      job_full;
  logic      job_pop;
  logic      job_empty;
  job_t      job_head;
  logic      strb_push;
  out_item_t strb;
  logic      strb_full;

  // writes to the enable pulse register are not stored by this block
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_wait_us   <= SETTLE_WAIT_RESET;
      cfg.home_wait_us     <= HOME_WAIT_RESET;
      cfg.power_up_wait_us <= POWER_UP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SETTLE_WAIT: cfg.settle_wait_us   <= cfg_data[14:0];
        REG_HOME_WAIT:   cfg.home_wait_us     <= cfg_data[14:0];
        REG_POWER_UP:    cfg.power_up_wait_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  clnw_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_in)
  );

  clnw_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_head),
    .empty   (job_empty)
  );

  clnw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .out_full  (strb_full),
    .out_push  (strb_push),
    .out_item  (strb)
  );

  clnw_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (strb_push),
    .wr_data (strb),
    .full    (strb_full),
    .rd_en   (pop),
    .rd_data (out_item),
    .empty   (empty)
  );

  a_no_strobe_into_full: assert property (@(posedge clk) disable iff (rst)
    !(strb_push && strb_full))
    else $error("strobe pushed into a full result queue");

  a_no_job_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(job_pop && job_empty))
    else $error("job taken from an empty job queue");

  a_power_up_on_high_nibble: assert property (@(posedge clk) disable iff (rst)
    (strb_push && (strb.wait_before_us != 16'd0)) |->
      (!strb.reg_select && (strb.wait_after_us == 16'd0) && !strb.last))
    else $error("power-up wait on a strobe other than the first init high nibble");

  a_last_then_new_job: assert property (@(posedge clk) disable iff (rst)
    (strb_push && strb.last) |=> !(strb_push && strb.wait_after_us != 16'd0 &&
      $past(strb_push) && $past(strb.last) && $past(job_empty)))
    else $error("strobe emitted after the last strobe with no job loaded");

endmodule

### tb/sv/char_lcd_nibble_writer_top_test.sv
// char_lcd_nibble_writer_top_test: self-checking bench for the 4-bit character lcd writer
// predicts every strobe per request from its own lcd model and compares in order
// depends on clnw_pkg and char_lcd_nibble_writer_top
module char_lcd_nibble_writer_top_test;
  import clnw_pkg::*;

  localparam int LINE_LEN = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PER_PHASE = 46;
  localparam int LONG_HOLD = 400;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;

  logic clk;
  logic rst;
  logic push;
  logic full;
  in_item_t in_item;
  logic empty;
  logic pop;
  out_item_t out_item;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  char_lcd_nibble_writer_top u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_item(in_item),
    .empty(empty),
    .pop(pop),
    .out_item(out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  in_item_t req_q[$];
  out_item_t strobe_q[$];
  out_item_t burst[$];

  logic [14:0] enable_us;
  logic [14:0] settle_us;
  logic [14:0] home_us;
  logic [15:0] power_up_us;
  logic lcd_ready = 1'b0;
  logic [7:0] cursor_pos = 8'd0;
  logic cursor_down = 1'b0;

  int errors = 0;
  int n_requests = 0;
  int n_strobes = 0;
  int n_settings;
  int n_full_stalls = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int take_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] clip16(int unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic add_strobe(logic rs, logic [3:0] nib, logic [15:0] pre_wait,
                            logic [15:0] post_wait);
    out_item_t s;
    s.reg_select = rs;
    s.nibble = nib;
    s.wait_before_us = pre_wait;
    s.wait_after_us = post_wait;
    s.last = 1'b0;
    burst.push_back(s);
  endtask

  task automatic send_byte(logic rs, logic [7:0] b, logic [15:0] pre_wait,
                           int unsigned extra);
    add_strobe(rs, b[7:4], pre_wait, 16'd0);
    add_strobe(rs, b[3:0], 16'd0, clip16(int'(settle_us) + extra));
  endtask

  task automatic send_instr(logic [7:0] b, logic [15:0] pre_wait, int unsigned extra);
    send_byte(1'b0, b, pre_wait, extra);
    if (b == CMD_INC || b == CMD_SHIFT_L) cursor_down = 1'b0;
    if (b == CMD_DEC || b == CMD_SHIFT_R) cursor_down = 1'b1;
  endtask

  task automatic send_clear_home();
    send_instr(CMD_CLEAR, 16'd0, 0);
    send_instr(CMD_HOME, 16'd0, int'(home_us) + int'(home_us));
    cursor_pos = 8'd0;
  endtask

  task automatic send_init();
    if (!lcd_ready) begin
      send_instr(CMD_INIT8, power_up_us, 0);
      send_instr(CMD_INIT4, 16'd0, 0);
      send_instr(CMD_FUNC, 16'd0, 0);
      send_instr(CMD_DISP_ON, 16'd0, 0);
      send_instr(CMD_INC, 16'd0, 0);
      send_clear_home();
      lcd_ready = 1'b1;
    end
  endtask

  task automatic expand_request(in_item_t req);
    out_item_t tail;
    burst.delete();
    case (req.opcode)
      OP_COMMAND: begin
        send_instr(req.byte_value, 16'd0, 0);
      end
      OP_CHAR: begin
        send_init();
        if (int'(cursor_pos) % (2 * LINE_LEN) == 0) begin
          send_clear_home();
          send_instr(CMD_LINE1, 16'd0, 0);
        end else if (int'(cursor_pos) % LINE_LEN == 0) begin
          send_instr(CMD_LINE2, 16'd0, 0);
        end
        send_byte(1'b1, req.byte_value, 16'd0, 0);
        cursor_pos = cursor_down ? cursor_pos - 8'd1 : cursor_pos + 8'd1;
      end
      OP_LOCATION: begin
        send_init();
        send_instr((req.row ? CMD_LINE2 : CMD_LINE1) + {4'd0, req.column}, 16'd0, 0);
        cursor_pos = 8'(int'(req.row) * LINE_LEN + int'(req.column));
      end
      OP_RAW: begin
        send_init();
        send_byte(1'b1, req.byte_value, 16'd0, 0);
      end
      OP_CLEAR: begin
        send_clear_home();
      end
      default: begin
      end
    endcase
    if (burst.size() > 0) begin
      tail = burst.pop_back();
      tail.last = 1'b1;
      burst.push_back(tail);
    end
    foreach (burst[i]) strobe_q.push_back(burst[i]);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_ENABLE_PULSE: enable_us = data[14:0];
      REG_SETTLE_WAIT: settle_us = data[14:0];
      REG_HOME_WAIT: home_us = data[14:0];
      REG_POWER_UP: power_up_us = data;
      default: begin
      end
    endcase
  endtask

  task automatic queue_req(logic [2:0] op, logic [7:0] b, logic [3:0] col, logic r);
    in_item_t req;
    req.opcode = op;
    req.byte_value = b;
    req.column = col;
    req.row = r;
    req_q.push_back(req);
  endtask

  function automatic in_item_t rand_request();
    in_item_t req;
    int pick;
    pick = $urandom_range(0, 99);
    req.byte_value = 8'($urandom);
    req.column = 4'($urandom);
    req.row = 1'($urandom);
    if (pick < 50) begin
      req.opcode = OP_CHAR;
    end else if (pick < 62) begin
      req.opcode = OP_LOCATION;
    end else if (pick < 72) begin
      req.opcode = OP_RAW;
    end else if (pick < 86) begin
      req.opcode = OP_COMMAND;
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0: req.byte_value = CMD_DEC;
          1: req.byte_value = CMD_SHIFT_R;
          2: req.byte_value = CMD_INC;
          default: req.byte_value = CMD_SHIFT_L;
        endcase
      end
    end else if (pick < 93) begin
      req.opcode = OP_CLEAR;
    end else begin
      req.opcode = 3'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)));
    end
    return req;
  endfunction

  task automatic wait_idle();
    do @(negedge clk); while (req_q.size() > 0 || strobe_q.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: strobe %0d %s expected %0h actual %0h", $time, n_strobes, name, want, got);
      errors++;
    end
  endtask

  // request side
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      in_item <= '0;
    end else if (send_gap > 0) begin
      push <= 1'b0;
      send_gap--;
    end else if (req_q.size() == 0) begin
      push <= 1'b0;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      send_gap = $urandom_range(0, 7);
    end else begin
      push <= 1'b1;
      in_item <= req_q[0];
    end
  end

  always @(posedge clk) begin
    if (!rst && push) begin
      if (!full) begin
        expand_request(in_item);
        void'(req_q.pop_front());
        n_requests++;
      end else begin
        n_full_stalls++;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (!hold_done && n_strobes > 50 && req_q.size() > 20) begin
      pop <= 1'b0;
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end else if (take_gap > 0) begin
      pop <= 1'b0;
      take_gap--;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      take_gap = $urandom_range(0, 7);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin : strobe_check
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (strobe_q.size() == 0) begin
        $display("%0t: unexpected strobe, expected none actual %h", $time, out_item);
        errors++;
      end else begin
        want = strobe_q.pop_front();
        check_field("reg_select", want.reg_select, out_item.reg_select);
        check_field("nibble", want.nibble, out_item.nibble);
        check_field("wait_before_us", want.wait_before_us, out_item.wait_before_us);
        check_field("wait_after_us", want.wait_after_us, out_item.wait_after_us);
        check_field("last", want.last, out_item.last);
      end
      n_strobes++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d strobes still expected", cycle_count,
               strobe_q.size());
      $display("[char_lcd_nibble_writer_top] ERROR");
      $finish;
    end
  end

  initial begin
    int made;
    in_item_t req;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    enable_us = 15'd1000;
    settle_us = SETTLE_WAIT_RESET;
    home_us = HOME_WAIT_RESET;
    power_up_us = POWER_UP_RESET;
    n_settings = 0;
    steady = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default settle and home waits, random power-up wait, only visible on the one init
    write_reg(REG_ENABLE_PULSE, 16'd1);
    write_reg(REG_POWER_UP, 16'($urandom));
    @(negedge clk);
    cfg_write <= 1'b0;
    n_settings++;
    queue_req(OP_COMMAND, 8'h00, 4'hF, 1'b1);
    queue_req(OP_COMMAND, 8'hFF, 4'h0, 1'b0);
    queue_req(OP_CLEAR, 8'hA5, 4'h5, 1'b1);
    queue_req(OP_SPARE_FIRST, 8'h5A, 4'hA, 1'b0);
    queue_req(OP_SPARE_LAST, 8'hFF, 4'hF, 1'b1);
    queue_req(OP_CHAR, 8'h41, 4'h3, 1'b1);
    queue_req(OP_CHAR, 8'hFF, 4'hF, 1'b1);
    queue_req(OP_LOCATION, 8'h00, 4'h0, 1'b1);
    queue_req(OP_CHAR, 8'h00, 4'h0, 1'b0);
    queue_req(OP_LOCATION, 8'hFF, 4'hF, 1'b1);
    queue_req(OP_CHAR, 8'h7E, 4'h1, 1'b0);
    queue_req(OP_CHAR, 8'h20, 4'h2, 1'b1);
    queue_req(OP_RAW, 8'h00, 4'h0, 1'b0);
    queue_req(OP_RAW, 8'hFF, 4'hF, 1'b1);
    queue_req(OP_COMMAND, CMD_DEC, 4'h0, 1'b0);
    queue_req(OP_LOCATION, 8'h00, 4'h0, 1'b0);
    queue_req(OP_CHAR, 8'h30, 4'h0, 1'b0);
    queue_req(OP_CHAR, 8'h31, 4'h0, 1'b0);
    queue_req(OP_COMMAND, CMD_SHIFT_L, 4'h0, 1'b0);
    queue_req(OP_COMMAND, CMD_SHIFT_R, 4'h0, 1'b0);
    queue_req(OP_COMMAND, CMD_INC, 4'h0, 1'b0);
    queue_req(OP_LOCATION, 8'h00, 4'hF, 1'b0);
    queue_req(OP_CHAR, 8'h42, 4'h0, 1'b0);
    queue_req(OP_CHAR, 8'h43, 4'h0, 1'b0);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_ENABLE_PULSE, 16'd20000);
          write_reg(REG_SETTLE_WAIT, 16'd0);
          write_reg(REG_HOME_WAIT, 16'd0);
        end
        1: begin
          write_reg(REG_ENABLE_PULSE, 16'h7FFF);
          write_reg(REG_SETTLE_WAIT, 16'hFFFF);
          write_reg(REG_HOME_WAIT, 16'h7FFF);
        end
        2: begin
          write_reg(REG_ENABLE_PULSE, 16'($urandom_range(1, 20000)));
          write_reg(REG_SETTLE_WAIT, 16'd20000);
          write_reg(REG_HOME_WAIT, 16'd20000);
        end
        default: begin
          write_reg(REG_ENABLE_PULSE, 16'($urandom_range(1, 20000)));
          write_reg(REG_SETTLE_WAIT, 16'($urandom_range(0, 20000)));
          write_reg(REG_HOME_WAIT, 16'($urandom_range(0, 20000)));
          steady = 1'b1;
        end
      endcase
      @(negedge clk);
      cfg_write <= 1'b0;
      n_settings++;
      made = 0;
      while (made < RAND_PER_PHASE) begin
        req = rand_request();
        req_q.push_back(req);
        if (req.opcode <= OP_CLEAR) made++;
      end
      wait_idle();
    end

    $display("covered %0d requests and %0d strobes over %0d timing settings, last pulse %0d us",
             n_requests, n_strobes, n_settings, enable_us);
    $display("input held off by full on %0d cycles, one long output stall included",
             n_full_stalls);
    if (errors == 0) begin
      $display("[char_lcd_nibble_writer_top] OK");
    end else begin
      $display("[char_lcd_nibble_writer_top] ERROR");
    end
    $finish;
  end

endmodule
